### rtl/rpm_pkg.sv
// rpm_pkg: shared types and constants of the ray-parity point-in-mesh core.
// No dependencies.
package rpm_pkg;

    localparam int CoordW = 32;
    localparam int CountBits = 24;
    localparam int TotalW = 24;
    localparam int CfgIdxW = 3;
    localparam int DiffW = 33;
    localparam int ProdW = 66;
    localparam int AccW = 104;

    localparam logic [CfgIdxW-1:0] RegOrgX = 3'd0;
    localparam logic [CfgIdxW-1:0] RegOrgY = 3'd1;
    localparam logic [CfgIdxW-1:0] RegOrgZ = 3'd2;
    localparam logic [CfgIdxW-1:0] RegDirX = 3'd3;
    localparam logic [CfgIdxW-1:0] RegDirY = 3'd4;
    localparam logic [CfgIdxW-1:0] RegDirZ = 3'd5;

    localparam logic signed [CoordW-1:0] DirXReset = 32'sd55044;
    localparam logic signed [CoordW-1:0] DirYReset = 32'sd20421;
    localparam logic signed [CoordW-1:0] DirZReset = 32'sd29118;

    typedef struct packed {
        logic signed [CoordW-1:0] a_x;
        logic signed [CoordW-1:0] a_y;
        logic signed [CoordW-1:0] a_z;
        logic signed [CoordW-1:0] b_x;
        logic signed [CoordW-1:0] b_y;
        logic signed [CoordW-1:0] b_z;
        logic signed [CoordW-1:0] c_x;
        logic signed [CoordW-1:0] c_y;
        logic signed [CoordW-1:0] c_z;
        logic                     last_tri;
    } t_tri;

    typedef struct packed {
        logic              inside_res;
        logic [TotalW-1:0] hit_total;
    } t_res;

endpackage

### rtl/rpm_mac.sv
// rpm_mac: shared multiply-accumulate unit of the ray-parity core.
// Depends on rpm_pkg. Signed 67x67-bit product split into four partial
// products of about 34x34 bits, then accumulated into a 104-bit register.
module rpm_mac (
    input  logic                      i_clk,
    input  logic                      i_start,
    input  logic                      i_clr,
    input  logic                      i_sub,
    input  logic signed [66:0]        i_a,
    input  logic signed [66:0]        i_b,
    output logic                      o_done,
    output logic signed [rpm_pkg::AccW-1:0] o_acc
);
    import rpm_pkg::*;

    // operands split: lo 33 bits unsigned, hi 34 bits signed
    logic signed [66:0]   r_a, r_b;
    logic [1:0]           r_ph;
    logic                 r_busy;
    logic                 r_clr, r_sub;
    logic signed [AccW-1:0] r_prod, r_acc;
    logic signed [34:0]   w_x, w_y;
    logic signed [69:0]   w_pp;
    logic signed [AccW-1:0] w_sh, w_prod_n;

    always_comb begin
        w_x = r_ph[0] ? 35'($signed(r_a[66:33])) : $signed({2'b00, r_a[32:0]});
        w_y = r_ph[1] ? 35'($signed(r_b[66:33])) : $signed({2'b00, r_b[32:0]});
        w_pp = w_x * w_y;
        case (r_ph)
            2'd0:    w_sh = AccW'(w_pp);
            2'd1,
            2'd2:    w_sh = AccW'(w_pp) <<< 33;
            default: w_sh = AccW'(w_pp) <<< 66;
        endcase
        w_prod_n = r_prod + w_sh;
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_ph <= 2'd0;
            r_busy <= 1'b1;
            r_prod <= '0;
            r_clr <= i_clr;
            r_sub <= i_sub;
        end else if (r_busy) begin
            r_prod <= w_prod_n;
            r_ph <= r_ph + 2'd1;
            if (r_ph == 2'd3) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
                r_acc <= (r_clr ? '0 : r_acc) + (r_sub ? -w_prod_n : w_prod_n);
            end
        end
    end
    assign o_acc = r_acc;
endmodule

### rtl/ray_parity_point_in_mesh_core.sv
// Top level of the ray-parity point-in-mesh core.
// Depends on rpm_pkg and rpm_mac.
//
// channel | valid     | stall     | payload
// in      | i_valid   | o_stall   | i_tri  (t_tri)
// out     | o_valid   | i_stall   | o_res  (t_res)
// cfg     | i_cfg_we  | -         | i_cfg_idx, i_cfg_data
//
// Each triangle takes 24 products on the shared MAC (start, four
// partial products, done back to the sequencer), plus a prep and a
// decision step; the next triangle is accepted only after the decision.
// Reset (synchronous, i_rst_n low) clears state, origin, counter and parity.
// o_stall is high from acceptance through the decision cycle; a last-triangle
// result sits in an output register and new items wait while it is held.
module ray_parity_point_in_mesh_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  rpm_pkg::t_tri                 i_tri,
    output logic                          o_valid,
    input  logic                          i_stall,
    output rpm_pkg::t_res                 o_res,
    input  logic                          i_cfg_we,
    input  logic [rpm_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [rpm_pkg::CoordW-1:0]    i_cfg_data
);
    import rpm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_MUL  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state;
    logic signed [CoordW-1:0] r_org [3];
    logic signed [CoordW-1:0] r_dir [3];
    t_tri r_tri;
    // e1, e2, s: 33-bit differences; p, q: cross products
    logic signed [DiffW-1:0] r_e1 [3], r_e2 [3], r_s [3];
    logic signed [66:0] r_p [3], r_q [3];
    logic signed [AccW-1:0] r_det, r_un, r_vn, r_tn;
    logic [4:0] r_op;
    logic r_parity;
    logic [CountBits-1:0] r_cnt;

    logic mac_start, mac_clr, mac_sub, mac_done;
    logic signed [66:0] mac_a, mac_b;
    logic signed [AccW-1:0] mac_acc;

    rpm_mac u_mac (
        .i_clk(i_clk), .i_start(mac_start), .i_clr(mac_clr), .i_sub(mac_sub),
        .i_a(mac_a), .i_b(mac_b), .o_done(mac_done), .o_acc(mac_acc)
    );

    function automatic logic signed [66:0] sx(input logic signed [DiffW-1:0] v);
        return 67'(v);
    endfunction

    // operation schedule: 0..5 p, 6..8 det, 9..14 q, 15..17 un, 18..20 vn,
    // 21..23 tn; cross products are pairs (first clears, second subtracts)
    always_comb begin
        mac_a = '0;
        mac_b = '0;
        mac_clr = 1'b0;
        mac_sub = 1'b0;
        case (r_op)
            5'd0:  begin mac_a = 67'(r_dir[1]); mac_b = sx(r_e2[2]); mac_clr = 1'b1; end
            5'd1:  begin mac_a = 67'(r_dir[2]); mac_b = sx(r_e2[1]); mac_sub = 1'b1; end
            5'd2:  begin mac_a = 67'(r_dir[2]); mac_b = sx(r_e2[0]); mac_clr = 1'b1; end
            5'd3:  begin mac_a = 67'(r_dir[0]); mac_b = sx(r_e2[2]); mac_sub = 1'b1; end
            5'd4:  begin mac_a = 67'(r_dir[0]); mac_b = sx(r_e2[1]); mac_clr = 1'b1; end
            5'd5:  begin mac_a = 67'(r_dir[1]); mac_b = sx(r_e2[0]); mac_sub = 1'b1; end
            5'd6:  begin mac_a = sx(r_e1[0]); mac_b = r_p[0]; mac_clr = 1'b1; end
            5'd7:  begin mac_a = sx(r_e1[1]); mac_b = r_p[1]; end
            5'd8:  begin mac_a = sx(r_e1[2]); mac_b = r_p[2]; end
            5'd9:  begin mac_a = sx(r_s[1]); mac_b = sx(r_e1[2]); mac_clr = 1'b1; end
            5'd10: begin mac_a = sx(r_s[2]); mac_b = sx(r_e1[1]); mac_sub = 1'b1; end
            5'd11: begin mac_a = sx(r_s[2]); mac_b = sx(r_e1[0]); mac_clr = 1'b1; end
            5'd12: begin mac_a = sx(r_s[0]); mac_b = sx(r_e1[2]); mac_sub = 1'b1; end
            5'd13: begin mac_a = sx(r_s[0]); mac_b = sx(r_e1[1]); mac_clr = 1'b1; end
            5'd14: begin mac_a = sx(r_s[1]); mac_b = sx(r_e1[0]); mac_sub = 1'b1; end
            5'd15: begin mac_a = sx(r_s[0]); mac_b = r_p[0]; mac_clr = 1'b1; end
            5'd16: begin mac_a = sx(r_s[1]); mac_b = r_p[1]; end
            5'd17: begin mac_a = sx(r_s[2]); mac_b = r_p[2]; end
            5'd18: begin mac_a = 67'(r_dir[0]); mac_b = r_q[0]; mac_clr = 1'b1; end
            5'd19: begin mac_a = 67'(r_dir[1]); mac_b = r_q[1]; end
            5'd20: begin mac_a = 67'(r_dir[2]); mac_b = r_q[2]; end
            5'd21: begin mac_a = sx(r_e2[0]); mac_b = r_q[0]; mac_clr = 1'b1; end
            5'd22: begin mac_a = sx(r_e2[1]); mac_b = r_q[1]; end
            5'd23: begin mac_a = sx(r_e2[2]); mac_b = r_q[2]; end
            default: ;
        endcase
    end

    // final decision: sign-normalize by det, then strict compares
    logic signed [AccW:0] w_d, w_u, w_v, w_t;
    logic w_hit;
    always_comb begin
        w_d = r_det[AccW-1] ? -(AccW+1)'(r_det) : (AccW+1)'(r_det);
        w_u = r_det[AccW-1] ? -(AccW+1)'(r_un)  : (AccW+1)'(r_un);
        w_v = r_det[AccW-1] ? -(AccW+1)'(r_vn)  : (AccW+1)'(r_vn);
        w_t = r_det[AccW-1] ? -(AccW+1)'(r_tn)  : (AccW+1)'(r_tn);
        w_hit = (w_d != 0) && (w_u > 0) && (w_u < w_d) && (w_v > 0)
              && ((w_u + w_v) < w_d) && (w_t > 0);
    end

    logic w_in_acc, w_out_busy;
    assign w_out_busy = o_valid;
    // decision cycle (r_op == 24) also holds the input off
    assign o_stall = (r_state != S_IDLE) || w_out_busy || (r_op == 5'd24);
    assign w_in_acc = i_valid && !o_stall;
    assign mac_start = (r_state == S_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_org[0] <= '0; r_org[1] <= '0; r_org[2] <= '0;
            r_dir[0] <= DirXReset; r_dir[1] <= DirYReset; r_dir[2] <= DirZReset;
            r_parity <= 1'b0;
            r_cnt <= '0;
            o_valid <= 1'b0;
            r_op <= '0;
        end else begin
            if (o_valid && !i_stall)
                o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegOrgX: r_org[0] <= i_cfg_data;
                    RegOrgY: r_org[1] <= i_cfg_data;
                    RegOrgZ: r_org[2] <= i_cfg_data;
                    RegDirX: r_dir[0] <= i_cfg_data;
                    RegDirY: r_dir[1] <= i_cfg_data;
                    RegDirZ: r_dir[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (w_in_acc) begin
                    r_tri <= i_tri;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_e1[0] <= DiffW'(r_tri.b_x) - DiffW'(r_tri.a_x);
                    r_e1[1] <= DiffW'(r_tri.b_y) - DiffW'(r_tri.a_y);
                    r_e1[2] <= DiffW'(r_tri.b_z) - DiffW'(r_tri.a_z);
                    r_e2[0] <= DiffW'(r_tri.c_x) - DiffW'(r_tri.a_x);
                    r_e2[1] <= DiffW'(r_tri.c_y) - DiffW'(r_tri.a_y);
                    r_e2[2] <= DiffW'(r_tri.c_z) - DiffW'(r_tri.a_z);
                    r_s[0] <= DiffW'(r_org[0]) - DiffW'(r_tri.a_x);
                    r_s[1] <= DiffW'(r_org[1]) - DiffW'(r_tri.a_y);
                    r_s[2] <= DiffW'(r_org[2]) - DiffW'(r_tri.a_z);
                    r_op <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_WAIT;
                S_WAIT: if (mac_done) begin
                    case (r_op)
                        5'd1:  r_p[0] <= 67'(mac_acc);
                        5'd3:  r_p[1] <= 67'(mac_acc);
                        5'd5:  r_p[2] <= 67'(mac_acc);
                        5'd8:  r_det <= mac_acc;
                        5'd10: r_q[0] <= 67'(mac_acc);
                        5'd12: r_q[1] <= 67'(mac_acc);
                        5'd14: r_q[2] <= 67'(mac_acc);
                        5'd17: r_un <= mac_acc;
                        5'd20: r_vn <= mac_acc;
                        5'd23: r_tn <= mac_acc;
                        default: ;
                    endcase
                    if (r_op == 5'd23) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_op <= r_op + 5'd1;
                        r_state <= S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // decision in the cycle after tn lands: r_op == 24 marks it
            if (r_state == S_WAIT && mac_done && r_op == 5'd23)
                r_op <= 5'd24;
            if (r_op == 5'd24) begin
                r_op <= '0;
                if (r_tri.last_tri) begin
                    o_valid <= 1'b1;
                    o_res.inside_res <= r_parity ^ w_hit;
                    o_res.hit_total <= TotalW'(
                        (w_hit && r_cnt != '1) ? r_cnt + 1'b1 : r_cnt);
                    r_parity <= 1'b0;
                    r_cnt <= '0;
                end else if (w_hit) begin
                    r_parity <= ~r_parity;
                    if (r_cnt != '1)
                        r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // input stalled while busy, result held under stall, count saturates
`ifndef SYNTHESIS
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res)) else $error("result lost");
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_cnt) == '1 && r_cnt != '0 |-> r_cnt == '1) else $error("count wrapped");
`endif
endmodule
